// ----- hdl/prr_pkg.sv -----
// Shared types, constants, CRC step and microcode table of the pairing request responder.
`default_nettype none

package prr_pkg;

    localparam int MAX_SLOTS = 32;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int CHK_W     = 8;
    localparam int ADDR_W    = 48;
    localparam int ID_W      = 6;
    localparam int ADDR_BYTES = ADDR_W / 8;
    localparam int BIDX_W    = $clog2(ADDR_BYTES);
    localparam int IN_W      = 56;
    localparam int OUT_W     = 16;
    localparam int PC_W      = 2;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h07;
    localparam logic [7:0] CRC_ZERO_SUB = 8'd8;
    localparam logic [BIDX_W-1:0] LAST_BYTE = BIDX_W'(ADDR_BYTES - 1);

    // Loop condition of a microcode step: when true, jump to the target.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_CRC_MORE,
        COND_SCAN_BUSY,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        logic            ld_in;
        logic            crc_en;
        logic            scan_en;
        logic            fin;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    localparam logic [PC_W-1:0] PC_ACCEPT = PC_W'(0);
    localparam logic [PC_W-1:0] PC_CRC    = PC_W'(1);
    localparam logic [PC_W-1:0] PC_SCAN   = PC_W'(2);
    localparam logic [PC_W-1:0] PC_FINISH = PC_W'(3);

    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{ld_in: 1'b0, crc_en: 1'b0, scan_en: 1'b0, fin: 1'b0,
               cond: COND_NEVER, target: PC_ACCEPT};
        case (pc)
            PC_ACCEPT:
            begin
                w.ld_in  = 1'b1;
                w.cond   = COND_NO_INPUT;
                w.target = PC_ACCEPT;
            end
            PC_CRC:
            begin
                w.crc_en = 1'b1;
                w.cond   = COND_CRC_MORE;
                w.target = PC_CRC;
            end
            PC_SCAN:
            begin
                w.scan_en = 1'b1;
                w.cond    = COND_SCAN_BUSY;
                w.target  = PC_SCAN;
            end
            PC_FINISH:
            begin
                w.fin    = 1'b1;
                w.cond   = COND_OUT_FULL;
                w.target = PC_FINISH;
            end
            default:
            begin
                w.cond = COND_NEVER;
            end
        endcase
        return w;
    endfunction

    // One byte of CRC-8, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pairing_request_responder_core.sv -----
// Top level of the pairing request responder: microcoded sequencer, CRC, table search and append.
`default_nettype none

// Channel      | Dir | Beat contents (lowest bit up)
// -------------+-----+---------------------------------------------------------
// s_axis       | in  | tdata[7:0] check_byte, tdata[55:8] device_address
// m_axis       | out | tdata[7:0] reply_check, [13:8] tracker_id,
//              |     | [14] was_added, [15] was_known
//
// A request runs from acceptance to its reply beat through one accept step,
// six CRC steps (one address byte each), one step per stored entry through
// the table read port and then a drain of the last compare, and one finish
// step. The single-port table read sets the search time.
// Reset clears the step counter, entry count and output valid; the table itself
// holds garbage until written and only entries below the count are compared.
// A reply beat waits in the output register while m_axis_tready is low; the next
// request is still accepted and processed, stalling only at its finish step.

module pairing_request_responder_core
    import prr_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire  [IN_W-1:0]  s_axis_tdata,   // check_byte, device_address
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // reply_check, tracker_id, was_added, was_known
);

    // Address table, read one entry per cycle with registered data.
    logic [ADDR_W-1:0] table_mem [MAX_SLOTS];
    logic [ADDR_W-1:0] rd_data_reg;
    logic              tbl_we;
    logic [SLOT_W-1:0] tbl_waddr;
    logic [SLOT_W-1:0] tbl_raddr;

    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [CHK_W-1:0]  chk_reg, chk_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]        crc_reg, crc_next;
    logic [BIDX_W-1:0] bidx_reg, bidx_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              cmp_pend_reg, cmp_pend_next;
    logic [SLOT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]  id_reg, id_next;
    logic              known_reg, known_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    uword_t            uw;
    logic              cond_hit;
    logic              rd_en;
    logic              out_full;
    logic [7:0]        crc_fix;
    logic              crc_ok;
    logic              addr_nz;
    logic              do_add;
    logic [7:0]        cur_byte;

    assign uw       = ucode_rom(pc_reg);
    assign out_full = out_valid_reg && !m_axis_tready;
    assign rd_en    = uw.scan_en && (scan_idx_reg < count_reg);
    assign addr_nz  = (addr_reg != '0);
    assign cur_byte = addr_reg[{bidx_reg, 3'b000} +: 8];
    assign crc_fix  = (crc_reg == 8'd0) ? CRC_ZERO_SUB : crc_reg;
    assign crc_ok   = (crc_fix == chk_reg);
    assign do_add   = uw.fin && !out_full && crc_ok && addr_nz && !known_reg
                      && (count_reg < CNT_W'(MAX_SLOTS));

    assign tbl_we    = do_add;
    assign tbl_waddr = count_reg[SLOT_W-1:0];
    assign tbl_raddr = scan_idx_reg[SLOT_W-1:0];

    assign s_axis_tready = uw.ld_in;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            table_mem[tbl_waddr] <= addr_reg;
        rd_data_reg <= table_mem[tbl_raddr];
    end

    // Pick the loop condition named by the control word.
    always_comb
    begin
        case (uw.cond)
            COND_NEVER:     cond_hit = 1'b0;
            COND_NO_INPUT:  cond_hit = !s_axis_tvalid;
            COND_CRC_MORE:  cond_hit = (bidx_reg != LAST_BYTE);
            COND_SCAN_BUSY: cond_hit = rd_en || cmp_pend_reg;
            COND_OUT_FULL:  cond_hit = out_full;
            default:        cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next        = cond_hit ? uw.target : pc_reg + PC_W'(1);
        chk_next       = chk_reg;
        addr_next      = addr_reg;
        crc_next       = crc_reg;
        bidx_next      = bidx_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_pend_next  = cmp_pend_reg;
        cmp_idx_next   = cmp_idx_reg;
        id_next        = id_reg;
        known_next     = known_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Drop the reply beat once taken.
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        // Latch the request and prime the datapath.
        if (uw.ld_in && s_axis_tvalid)
        begin
            chk_next      = s_axis_tdata[CHK_W-1:0];
            addr_next     = s_axis_tdata[CHK_W +: ADDR_W];
            crc_next      = CRC_INIT;
            bidx_next     = '0;
            scan_idx_next = '0;
            cmp_pend_next = 1'b0;
            id_next       = count_reg;
            known_next    = 1'b0;
        end

        // Fold one address byte into the CRC, lowest byte first.
        if (uw.crc_en)
        begin
            crc_next  = crc8_byte(crc_reg, cur_byte);
            bidx_next = bidx_reg + BIDX_W'(1);
        end

        // Issue one table read and compare the data of the read issued in the previous step.
        if (uw.scan_en)
        begin
            if (cmp_pend_reg && addr_nz && (rd_data_reg == addr_reg))
            begin
                id_next    = CNT_W'(cmp_idx_reg);
                known_next = 1'b1;
            end
            cmp_pend_next = rd_en;
            cmp_idx_next  = scan_idx_reg[SLOT_W-1:0];
            if (rd_en)
                scan_idx_next = scan_idx_reg + CNT_W'(1);
        end

        // Decide, append and load the reply beat.
        if (uw.fin && !out_full)
        begin
            if (do_add)
                count_next = count_reg + CNT_W'(1);
            out_valid_next = 1'b1;
            out_data_next  = {known_reg, do_add, ID_W'(id_reg),
                              (crc_ok && (id_reg < CNT_W'(MAX_SLOTS))) ? chk_reg : '0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_ACCEPT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            cmp_pend_reg  <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            cmp_pend_reg  <= cmp_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg      <= chk_next;
        addr_reg     <= addr_next;
        crc_reg      <= crc_next;
        bidx_reg     <= bidx_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        id_reg       <= id_next;
        known_reg    <= known_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ----- test/tb_pairing_request_responder_core.sv -----
// Self-checking testbench for the pairing request responder core.
`timescale 1ns / 100ps

module tb_pairing_request_responder_core;

    import prr_pkg::*;

    // A correct run stays well below this limit even with the longest gaps
    // and stalls; the limit leaves several times the run that it needs.
    localparam int unsigned CYCLE_LIMIT = 800000;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned MAX_SHOWN = 10;

    // One reply beat, packed exactly as m_axis_tdata (lowest field last).
    typedef struct packed {
        logic            was_known;
        logic            was_added;
        logic [ID_W-1:0] tracker_id;
        logic [CHK_W-1:0] reply_check;
    } reply_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;   // check_byte, device_address
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // reply_check, tracker_id, was_added, was_known

    // Shadow of the pairing state, advanced at each accepted request.
    logic [ADDR_W-1:0] paired_addr [MAX_SLOTS];
    int unsigned       pair_count;

    reply_t      pending_replies [$];
    int unsigned error_count;
    int unsigned cycle_count;
    bit          no_gaps;

    pairing_request_responder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_pairing_request_responder_core: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // CRC-8 over the address bytes, low byte first, each byte MSB first,
    // computed one bit at a time as a plain shift register.
    function automatic logic [7:0] crc8_of_address(input logic [ADDR_W-1:0] addr);
        logic [7:0] crc;
        logic       fb;
        crc = CRC_INIT;
        for (int i = 0; i < ADDR_W / 8; i++)
        begin
            for (int b = 7; b >= 0; b--)
            begin
                fb  = crc[7] ^ addr[8 * i + b];
                crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
        end
        return crc;
    endfunction

    // Check byte the device must send; a zero CRC is replaced.
    function automatic logic [7:0] expected_check(input logic [ADDR_W-1:0] addr);
        logic [7:0] c;
        c = crc8_of_address(addr);
        return (c == 8'h00) ? CRC_ZERO_SUB : c;
    endfunction

    // Look the address up, append it when acceptable, and form the reply.
    function automatic reply_t answer_request(input logic [7:0] chk,
                                              input logic [ADDR_W-1:0] addr);
        reply_t      r;
        int unsigned slot;
        bit          known;
        bit          ok;
        slot  = pair_count;
        known = 1'b0;
        // Scan upward so the highest matching slot wins.
        for (int i = 0; i < pair_count; i++)
        begin
            if (addr != '0 && paired_addr[i] == addr)
            begin
                slot  = i;
                known = 1'b1;
            end
        end
        ok            = (expected_check(addr) == chk);
        r.was_known   = known;
        r.was_added   = ok && addr != '0 && !known && pair_count < MAX_SLOTS;
        r.tracker_id  = ID_W'(slot);
        r.reply_check = (ok && slot < MAX_SLOTS) ? chk : 8'h00;
        if (r.was_added)
        begin
            paired_addr[pair_count] = addr;
            pair_count++;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly dense random addresses, sometimes at most one nonzero byte.
    function automatic logic [ADDR_W-1:0] random_address();
        logic [ADDR_W-1:0] a;
        a = {16'($urandom), 32'($urandom)};
        if ($urandom_range(0, 9) == 0)
            a = ADDR_W'($urandom_range(0, 255)) << (8 * $urandom_range(0, 5));
        return a;
    endfunction

    function automatic bit is_paired(input logic [ADDR_W-1:0] addr);
        for (int i = 0; i < pair_count; i++)
        begin
            if (paired_addr[i] == addr)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Nonzero address not stored yet whose raw CRC is the given value.
    function automatic logic [ADDR_W-1:0] address_with_crc(input logic [7:0] want);
        logic [ADDR_W-1:0] a;
        a = random_address();
        while (a == '0 || is_paired(a) || crc8_of_address(a) != want)
            a = {16'($urandom), 32'($urandom)};
        return a;
    endfunction

    function automatic logic [ADDR_W-1:0] fresh_address();
        logic [ADDR_W-1:0] a;
        a = random_address();
        while (a == '0 || is_paired(a))
            a = random_address();
        return a;
    endfunction

    // Present one request beat and predict its reply once it is taken.
    // Called and returns at a falling edge; tvalid stays high afterwards.
    task automatic send_request(input logic [7:0] chk, input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {addr, chk};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_replies.push_back(answer_request(chk, addr));
        @(negedge clk);
    endtask

    // Hold off new requests until every reply is back.
    task automatic wait_for_replies();
        s_axis_tvalid = 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Reply side: random back-pressure and checking
    // ------------------------------------------------------------------

    initial
    begin
        int unsigned stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            // Keep ready high until a beat is taken.
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic flag_error(input string what, input int unsigned want,
                              input int unsigned got);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("reply %s: expected %0d, got %0d", what, want, got);
    endtask

    task automatic check_reply(input reply_t got);
        reply_t want;
        if (pending_replies.size() == 0)
        begin
            flag_error("beat without request (data)", 0, 32'(got));
            return;
        end
        want = pending_replies.pop_front();
        if (got.reply_check !== want.reply_check)
            flag_error("reply_check", 32'(want.reply_check), 32'(got.reply_check));
        if (got.tracker_id !== want.tracker_id)
            flag_error("tracker_id", 32'(want.tracker_id), 32'(got.tracker_id));
        if (got.was_added !== want.was_added)
            flag_error("was_added", 32'(want.was_added), 32'(got.was_added));
        if (got.was_known !== want.was_known)
            flag_error("was_known", 32'(want.was_known), 32'(got.was_known));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_reply(m_axis_tdata);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero address: never stored, but a good check is still echoed.
    task automatic test_zero_address();
        send_request(expected_check('0), '0);
        send_request(expected_check('0) ^ 8'h01, '0);
        send_request(8'h00, '0);
    endtask

    // Check byte extremes, the zero CRC substitution, address bit extremes,
    // repeat and bad-check requests for stored devices.
    task automatic test_check_corners();
        logic [ADDR_W-1:0] a;
        a = '1;
        send_request(8'h00, a);
        send_request(expected_check(a), a);
        send_request(expected_check(a), a);
        send_request(expected_check(a) ^ 8'h80, a);
        // Raw CRC of zero must be answered with the substitute.
        a = address_with_crc(8'h00);
        send_request(8'h00, a);
        send_request(CRC_ZERO_SUB, a);
        send_request(CRC_ZERO_SUB, a);
        a = address_with_crc(8'hFF);
        send_request(8'hFF, a);
        send_request(8'hFF, a);
        a = ADDR_W'(1);
        send_request(expected_check(a), a);
        a = {1'b1, {(ADDR_W - 1){1'b0}}};
        send_request(expected_check(a), a);
        a = fresh_address();
        send_request(expected_check(a) ^ 8'h5A, a);
        send_request(8'hFF, fresh_address());
    endtask

    // Mixed traffic: repeats of stored devices, new devices at add_pct
    // percent, zero addresses, near-miss and random checks.
    task automatic test_random_traffic(input int unsigned n_items,
                                       input int unsigned add_pct);
        logic [7:0]        chk;
        logic [ADDR_W-1:0] addr;
        int unsigned       pick;
        for (int k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < add_pct)
            begin
                addr = fresh_address();
                chk  = expected_check(addr);
            end
            else if (pick < 50 && pair_count > 0)
            begin
                addr = paired_addr[$urandom_range(0, pair_count - 1)];
                chk  = ($urandom_range(0, 4) != 0) ? expected_check(addr) : 8'($urandom);
            end
            else if (pick < 56)
            begin
                addr = '0;
                chk  = $urandom_range(0, 1) ? expected_check(addr) : 8'($urandom);
            end
            else if (pick < 75)
            begin
                addr = random_address();
                chk  = expected_check(addr) ^ 8'($urandom_range(1, 255));
            end
            else
            begin
                addr = random_address();
                chk  = 8'($urandom);
            end
            send_request(chk, addr);
        end
    endtask

    // No idling on either side.
    task automatic test_back_to_back();
        no_gaps = 1'b1;
        test_random_traffic(150, 3);
        no_gaps = 1'b0;
    endtask

    // Fill every slot, then probe the full table.
    task automatic test_table_full();
        logic [ADDR_W-1:0] a;
        while (pair_count < MAX_SLOTS)
        begin
            a = fresh_address();
            send_request(expected_check(a), a);
        end
        a = fresh_address();
        send_request(expected_check(a), a);
        send_request(expected_check(a) ^ 8'h01, a);
        send_request(expected_check(paired_addr[0]), paired_addr[0]);
        send_request(expected_check(paired_addr[MAX_SLOTS - 1]), paired_addr[MAX_SLOTS - 1]);
        send_request(expected_check('0), '0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        no_gaps       = 1'b0;
        pair_count    = 0;
        error_count   = 0;
        for (int i = 0; i < MAX_SLOTS; i++)
            paired_addr[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_address();
        test_check_corners();
        // Slow fill so searches run over every table depth.
        test_random_traffic(950, 3);
        // Drain completely before the burst.
        wait_for_replies();
        test_back_to_back();
        test_table_full();
        test_random_traffic(650, 15);

        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_replies.size() == 0)
            $display("tb_pairing_request_responder_core: clean");
        else
            $display("tb_pairing_request_responder_core: errors");
        $finish;
    end

endmodule
